// File: rtl/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg
// Types and constants shared by the two-class priority queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

    localparam int CLASS_DEPTH_DEF = 16;
    localparam int ITEM_W          = 32;
    localparam int DIVISOR_W       = 16;
    localparam int DIV_STEPS       = ITEM_W;
    localparam int OPQ_DEPTH       = 2;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_PEEK    = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_PEEK  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        CFG_CHAR_MODE = 1'b0,
        CFG_DIVISOR   = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        OP_ENQ_PRI  = 2'd0,
        OP_ENQ_NORM = 2'd1,
        OP_DEQUEUE  = 2'd2,
        OP_PEEK     = 2'd3
    } op_kind_t;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [ITEM_W-1:0] item;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [ITEM_W-1:0] head_value;
    } rsp_t;

    // classified operation passed from front to back
    typedef struct packed {
        op_kind_t          kind;
        logic [ITEM_W-1:0] value;
    } op_t;

endpackage

// File: rtl/tcpq_ram.sv
// ----------------------------------------------------------------------------
// tcpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/tcpq_front.sv
// ----------------------------------------------------------------------------
// tcpq_front
// Accepts request items, classifies enqueues (vowel test or iterative
// restoring remainder) and hands classified operations to the op queue.
// ----------------------------------------------------------------------------
module tcpq_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 char_mode,
    input  logic [tcpq_pkg::DIVISOR_W-1:0]       divisor,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  tcpq_pkg::req_t                       req,
    output logic                                 op_valid,
    input  logic                                 op_ready,
    output tcpq_pkg::op_t                        op
);

    import tcpq_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS);
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_E = 8'h65;
    localparam logic [7:0] CH_I = 8'h69;
    localparam logic [7:0] CH_O = 8'h6f;
    localparam logic [7:0] CH_U = 8'h75;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_PUSH = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [ITEM_W-1:0]      dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0]   rem_reg, rem_next;
    logic [STEP_W-1:0]      step_reg, step_next;

    logic [ITEM_W-1:0]      item_u;
    logic [ITEM_W-1:0]      mag;
    logic                   vowel;
    logic [DIVISOR_W:0]     trial;
    logic [DIVISOR_W:0]     diff;
    logic [DIVISOR_W-1:0]   rem_step;

    assign item_u = req.item;
    assign mag    = item_u[ITEM_W-1] ? (ITEM_W'(0) - item_u) : item_u;
    assign vowel  = (item_u[7:0] == CH_A) || (item_u[7:0] == CH_E) ||
                    (item_u[7:0] == CH_I) || (item_u[7:0] == CH_O) ||
                    (item_u[7:0] == CH_U);

    assign trial    = {rem_reg, dvd_reg[ITEM_W-1]};
    assign diff     = trial - {1'b0, divisor};
    assign rem_step = (trial >= {1'b0, divisor}) ? diff[DIVISOR_W-1:0]
                                                 : trial[DIVISOR_W-1:0];

    assign req_ready = (state_reg == S_IDLE);
    assign op_valid  = (state_reg == S_PUSH);
    assign op        = op_reg;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next.value = '0;
                    unique case (req.command)
                        CMD_ENQUEUE:
                        begin
                            if (char_mode)
                            begin
                                op_next.value = {{(ITEM_W-8){1'b0}}, item_u[7:0]};
                                op_next.kind  = vowel ? OP_ENQ_PRI : OP_ENQ_NORM;
                                state_next    = S_PUSH;
                            end
                            else if (divisor == '0)
                            begin
                                op_next.value = item_u;
                                op_next.kind  = (mag == '0) ? OP_ENQ_PRI : OP_ENQ_NORM;
                                state_next    = S_PUSH;
                            end
                            else
                            begin
                                op_next.value = item_u;
                                dvd_next      = mag;
                                rem_next      = '0;
                                step_next     = STEP_W'(DIV_STEPS - 1);
                                state_next    = S_DIV;
                            end
                        end
                        CMD_DEQUEUE:
                        begin
                            op_next.kind = OP_DEQUEUE;
                            state_next   = S_PUSH;
                        end
                        CMD_PEEK:
                        begin
                            op_next.kind = OP_PEEK;
                            state_next   = S_PUSH;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                rem_next  = rem_step;
                dvd_next  = {dvd_reg[ITEM_W-2:0], 1'b0};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    op_next.kind = (rem_step == '0) ? OP_ENQ_PRI : OP_ENQ_NORM;
                    state_next   = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (op_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
    end

`ifndef SYNTHESIS
    a_div_ends_in_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) && (step_reg == '0) |=> (state_reg == S_PUSH))
        else $error("division did not end in push");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) && (divisor != '0) |-> (rem_reg < divisor))
        else $error("partial remainder not below divisor");

    a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH) && !op_ready |=> (state_reg == S_PUSH) && $stable(op_reg))
        else $error("stalled op changed");
`endif

endmodule

// File: rtl/tcpq_opq.sv
// ----------------------------------------------------------------------------
// tcpq_opq
// Short register queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module tcpq_opq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  tcpq_pkg::op_t   push_op,
    output logic            pop_valid,
    input  logic            pop_ready,
    output tcpq_pkg::op_t   pop_op
);

    import tcpq_pkg::*;

    localparam int PTR_W = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(OPQ_DEPTH + 1);

    op_t              entry_reg [OPQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(OPQ_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// File: rtl/tcpq_back.sv
// ----------------------------------------------------------------------------
// tcpq_back
// Executes classified operations on the two class FIFOs and registers the
// response item.
// ----------------------------------------------------------------------------
module tcpq_back #(
    parameter int CLASS_DEPTH = tcpq_pkg::CLASS_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            op_valid,
    output logic            op_ready,
    input  tcpq_pkg::op_t   op,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output tcpq_pkg::rsp_t  rsp
);

    import tcpq_pkg::*;

    localparam int PTR_W = $clog2(CLASS_DEPTH);
    localparam int CNT_W = $clog2(CLASS_DEPTH + 1);

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_READ = 2'b10
    } bstate_t;

    bstate_t           state_reg, state_next;
    logic              sel_pri_reg, sel_pri_next;
    logic [PTR_W-1:0]  pri_head_reg, pri_head_next, pri_tail_reg, pri_tail_next;
    logic [PTR_W-1:0]  norm_head_reg, norm_head_next, norm_tail_reg, norm_tail_next;
    logic [CNT_W-1:0]  pri_count_reg, pri_count_next, norm_count_reg, norm_count_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic              take;
    logic              pri_full, norm_full, pri_empty, norm_empty;
    logic              pri_wr_en, norm_wr_en;
    logic [ITEM_W-1:0] pri_rd_data, norm_rd_data;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(CLASS_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign pri_full   = (pri_count_reg == CNT_W'(CLASS_DEPTH));
    assign norm_full  = (norm_count_reg == CNT_W'(CLASS_DEPTH));
    assign pri_empty  = (pri_count_reg == '0);
    assign norm_empty = (norm_count_reg == '0);

    assign op_ready   = (state_reg == B_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign take       = op_valid && op_ready;
    assign pri_wr_en  = take && (op.kind == OP_ENQ_PRI) && !pri_full;
    assign norm_wr_en = take && (op.kind == OP_ENQ_NORM) && !norm_full;

    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    always_comb
    begin
        state_next      = state_reg;
        sel_pri_next    = sel_pri_reg;
        pri_head_next   = pri_head_reg;
        pri_tail_next   = pri_tail_reg;
        pri_count_next  = pri_count_reg;
        norm_head_next  = norm_head_reg;
        norm_tail_next  = norm_tail_reg;
        norm_count_next = norm_count_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_next        = rsp_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (take)
                begin
                    unique case (op.kind)
                        OP_ENQ_PRI:
                        begin
                            if (pri_full)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next       = '{status: ST_FULL, head_value: '0};
                            end
                            else
                            begin
                                pri_tail_next  = wrap_inc(pri_tail_reg);
                                pri_count_next = pri_count_reg + 1'b1;
                            end
                        end
                        OP_ENQ_NORM:
                        begin
                            if (norm_full)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next       = '{status: ST_FULL, head_value: '0};
                            end
                            else
                            begin
                                norm_tail_next  = wrap_inc(norm_tail_reg);
                                norm_count_next = norm_count_reg + 1'b1;
                            end
                        end
                        OP_DEQUEUE:
                        begin
                            priority if (!pri_empty)
                            begin
                                pri_head_next  = wrap_inc(pri_head_reg);
                                pri_count_next = pri_count_reg - 1'b1;
                            end
                            else if (!norm_empty)
                            begin
                                norm_head_next  = wrap_inc(norm_head_reg);
                                norm_count_next = norm_count_reg - 1'b1;
                            end
                            else
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next       = '{status: ST_EMPTY, head_value: '0};
                            end
                        end
                        OP_PEEK:
                        begin
                            if (pri_empty && norm_empty)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next       = '{status: ST_EMPTY, head_value: '0};
                            end
                            else
                            begin
                                sel_pri_next = !pri_empty;
                                state_next   = B_READ;
                            end
                        end
                        default:
                        begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end
            B_READ:
            begin
                // head word registered by the RAM on the previous edge
                rsp_valid_next = 1'b1;
                rsp_next       = '{status: ST_PEEK,
                                   head_value: sel_pri_reg ? pri_rd_data : norm_rd_data};
                state_next     = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            pri_head_reg   <= '0;
            pri_tail_reg   <= '0;
            pri_count_reg  <= '0;
            norm_head_reg  <= '0;
            norm_tail_reg  <= '0;
            norm_count_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pri_head_reg   <= pri_head_next;
            pri_tail_reg   <= pri_tail_next;
            pri_count_reg  <= pri_count_next;
            norm_head_reg  <= norm_head_next;
            norm_tail_reg  <= norm_tail_next;
            norm_count_reg <= norm_count_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_pri_reg <= sel_pri_next;
        rsp_reg     <= rsp_next;
    end

    tcpq_ram #(
        .WIDTH (ITEM_W),
        .DEPTH (CLASS_DEPTH)
    ) u_pri_ram (
        .clk     (clk),
        .wr_en   (pri_wr_en),
        .wr_addr (pri_tail_reg),
        .wr_data (op.value),
        .rd_addr (pri_head_reg),
        .rd_data (pri_rd_data)
    );

    tcpq_ram #(
        .WIDTH (ITEM_W),
        .DEPTH (CLASS_DEPTH)
    ) u_norm_ram (
        .clk     (clk),
        .wr_en   (norm_wr_en),
        .wr_addr (norm_tail_reg),
        .wr_data (op.value),
        .rd_addr (norm_head_reg),
        .rd_data (norm_rd_data)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (pri_count_reg <= CNT_W'(CLASS_DEPTH)) && (norm_count_reg <= CNT_W'(CLASS_DEPTH)))
        else $error("class count above depth");

    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_READ) |-> !rsp_valid_reg)
        else $error("peek read with response slot occupied");

    a_read_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_READ) |=> rsp_valid_reg && (rsp_reg.status == ST_PEEK))
        else $error("peek read gave no response");

    a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(pri_wr_en && pri_full) && !(norm_wr_en && norm_full))
        else $error("write into full class");
`endif

endmodule

// File: rtl/two_class_priority_queue.sv
// ----------------------------------------------------------------------------
// two_class_priority_queue
// Strict-priority queue with two FIFO classes; enqueued items are classified
// on entry by divisibility (integer mode) or lowercase vowel (character mode).
//
//   channel  signals                              direction
//   req      req_valid / req_ready / req          request items in
//   rsp      rsp_valid / rsp_ready / rsp          response items out
//   cfg      cfg_valid / cfg_ready / cfg_index,   register writes in
//            cfg_data
//
// Integer-mode enqueue with a non-zero divisor runs the bit-serial restoring
// remainder in the front (one quotient bit per cycle over 32 bits); other
// requests pass the front without it, and peek adds a RAM read in the back.
// A 2-entry op queue lets the front keep classifying while the back or the
// response register stalls. cfg_ready is always high.
// Reset: both classes empty, char_mode 0, divisor 2; no clearing pass.
// ----------------------------------------------------------------------------
module two_class_priority_queue #(
    parameter int CLASS_DEPTH = tcpq_pkg::CLASS_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  tcpq_pkg::req_t                  req,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output tcpq_pkg::rsp_t                  rsp,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  tcpq_pkg::cfg_index_t            cfg_index,
    input  logic [tcpq_pkg::DIVISOR_W-1:0]  cfg_data
);

    import tcpq_pkg::*;

    logic                 char_mode_reg;
    logic [DIVISOR_W-1:0] divisor_reg;

    logic                 fq_valid, fq_ready;
    op_t                  fq_op;
    logic                 qb_valid, qb_ready;
    op_t                  qb_op;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_mode_reg <= 1'b0;
            divisor_reg   <= DIVISOR_W'(2);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CHAR_MODE: char_mode_reg <= cfg_data[0];
                CFG_DIVISOR:   divisor_reg   <= cfg_data;
                default:       divisor_reg   <= divisor_reg;
            endcase
        end
    end

    tcpq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_mode (char_mode_reg),
        .divisor   (divisor_reg),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .op_valid  (fq_valid),
        .op_ready  (fq_ready),
        .op        (fq_op)
    );

    tcpq_opq u_opq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_op    (fq_op),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_op     (qb_op)
    );

    tcpq_back #(
        .CLASS_DEPTH (CLASS_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (qb_valid),
        .op_ready  (qb_ready),
        .op        (qb_op),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
